// ===== rtl/pwg_pkg.sv =====
// Package for the plasma word generator: shared types, constants and the
// parabolic sine function used to load the table RAM and to form the row term.
// No dependencies.
package pwg_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAw    = 8;
  localparam int unsigned SineW      = 7;
  localparam int unsigned PixPerWord = 16;
  localparam int unsigned PixIdxW    = 4;

  typedef logic signed [SineW-1:0] sine_t;
  typedef logic [TableAw-1:0]      tab_addr_t;
  typedef logic [PixIdxW-1:0]      pix_idx_t;

  // Tag that travels alongside a table read, aligned with the read data.
  typedef struct packed {
    logic  vld;
    logic  last;
    sine_t ysin;
  } rd_tag_t;

  // Parabolic sine: entries lie in -32..32. The last quarter uses a floor of
  // the negated product, done on a biased non-negative value.
  function automatic sine_t sine_value(input tab_addr_t idx);
    int i;
    int h;
    int r;
    i = int'(idx);
    h = int'(idx[6:0]);
    if (i < 64) begin
      r = (i * (128 - 2 * i)) >>> 6;
    end else if (i < 128) begin
      r = ((128 - i) * (2 * i - 128)) >>> 6;
    end else if (h < 64) begin
      r = -((h * (128 - 2 * h)) >>> 6);
    end else begin
      r = -((((128 - h) * (2 * h - 128)) + 63) >>> 6);
    end
    return sine_t'(r);
  endfunction

endpackage

// ===== rtl/pwg_if.sv =====
// Valid/ready channel interfaces for the plasma word generator.
// The request carries frame, row and word index; the response two bit-plane words.
interface pwg_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame;
  logic [6:0] row;
  logic [3:0] word_index;

  modport source (output valid, output frame, output row, output word_index, input ready);
  modport sink   (input valid, input frame, input row, input word_index, output ready);
endinterface

interface pwg_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] light_word;
  logic [15:0] dark_word;

  modport source (output valid, output light_word, output dark_word, input ready);
  modport sink   (input valid, input light_word, input dark_word, output ready);
endinterface

// ===== rtl/pwg_ram.sv =====
// Generic simple RAM: one write port, two read ports with registered read data.
// No dependencies.
module pwg_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                          rdata_a_o,
  output logic [WIDTH-1:0]                          rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/pwg_issue.sv =====
// Request intake, table load sweep and per-pixel read sequencer.
// Depends on pwg_pkg and pwg_req_if.
module pwg_issue (
  input  logic               clk_i,
  input  logic               rst_ni,
  pwg_req_if.sink            req_i,
  input  logic               hold_i,
  output logic               tab_we_o,
  output pwg_pkg::tab_addr_t tab_waddr_o,
  output pwg_pkg::sine_t     tab_wdata_o,
  output pwg_pkg::tab_addr_t raddr_a_o,
  output pwg_pkg::tab_addr_t raddr_b_o,
  output pwg_pkg::rd_tag_t   tag_o
);
  import pwg_pkg::*;

  localparam pix_idx_t LastPix = pix_idx_t'(PixPerWord - 1);

  logic      fill_done_q;
  tab_addr_t fill_idx_q;
  logic      busy_q;
  pix_idx_t  pix_q;
  logic [7:0] frame_q;
  tab_addr_t  yframe_q;
  logic [3:0] word_q;
  sine_t      ysin_q;
  rd_tag_t    tag_q;

  logic       accept;
  logic       issue_go;
  logic [8:0] yframe_sum;
  tab_addr_t  ysin_idx;
  tab_addr_t  px;

  assign req_i.ready = fill_done_q && !hold_i && (!busy_q || (pix_q == LastPix));
  assign accept      = req_i.valid && req_i.ready;
  assign issue_go    = busy_q && !hold_i;

  assign yframe_sum = {2'b00, req_i.row} + {1'b0, req_i.frame};
  assign ysin_idx   = {1'b0, req_i.row} + {1'b0, req_i.frame[7:1]};

  // Table load after reset, one entry a cycle.
  assign tab_we_o    = !fill_done_q;
  assign tab_waddr_o = fill_idx_q;
  assign tab_wdata_o = sine_value(fill_idx_q);

  assign px        = {word_q, pix_q};
  assign raddr_a_o = px + frame_q;
  assign raddr_b_o = px + yframe_q;
  assign tag_o     = tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_done_q <= 1'b0;
      fill_idx_q  <= '0;
      busy_q      <= 1'b0;
      pix_q       <= '0;
      tag_q       <= '0;
    end else begin
      if (!fill_done_q) begin
        fill_idx_q <= fill_idx_q + 1'b1;
        if (fill_idx_q == tab_addr_t'(TableDepth - 1)) begin
          fill_done_q <= 1'b1;
        end
      end
      if (issue_go) begin
        pix_q <= pix_q + 1'b1;
        if (pix_q == LastPix) begin
          busy_q <= accept;
        end
      end else if (accept) begin
        busy_q <= 1'b1;
        pix_q  <= '0;
      end
      tag_q.vld  <= issue_go;
      tag_q.last <= (pix_q == LastPix);
      tag_q.ysin <= ysin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q  <= req_i.frame;
      yframe_q <= yframe_sum[8:1];
      word_q   <= req_i.word_index;
      ysin_q   <= sine_value(ysin_idx);
    end
  end

endmodule

// ===== rtl/pwg_shade.sv =====
// Per-pixel gray level, bit-plane shift registers and the output buffer with
// a one-word holding slot. Depends on pwg_pkg and pwg_rsp_if.
module pwg_shade (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pwg_pkg::sine_t   rdata_a_i,
  input  pwg_pkg::sine_t   rdata_b_i,
  input  pwg_pkg::rd_tag_t tag_i,
  output logic             hold_o,
  pwg_rsp_if.source        rsp_o
);
  import pwg_pkg::*;

  logic signed [8:0] sum;
  logic signed [3:0] lvl_raw;
  logic [1:0]        lvl;
  logic [15:0]       light_acc_q;
  logic [15:0]       dark_acc_q;
  logic [15:0]       light_word;
  logic [15:0]       dark_word;
  logic              done;
  logic              out_free;
  logic              out_valid_q;
  logic [15:0]       out_light_q;
  logic [15:0]       out_dark_q;
  logic              pend_valid_q;
  logic [15:0]       pend_light_q;
  logic [15:0]       pend_dark_q;

  assign sum     = 9'(rdata_a_i) + 9'(rdata_b_i) + 9'(tag_i.ysin);
  // The top four bits of the sum are its floor division by 32.
  assign lvl_raw = $signed(sum[8:5]) + 4'sd2;

  always_comb begin
    if (lvl_raw < 0) begin
      lvl = 2'd0;
    end else if (lvl_raw > 4'sd3) begin
      lvl = 2'd3;
    end else begin
      lvl = lvl_raw[1:0];
    end
  end

  assign light_word = {light_acc_q[14:0], lvl[1]};
  assign dark_word  = {dark_acc_q[14:0], lvl[0]};
  assign done       = tag_i.vld && tag_i.last;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign hold_o     = pend_valid_q;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.light_word = out_light_q;
  assign rsp_o.dark_word  = out_dark_q;

  always_ff @(posedge clk_i) begin
    if (tag_i.vld) begin
      light_acc_q <= light_word;
      dark_acc_q  <= dark_word;
    end
  end

  // A finished word goes straight out when the output register frees up and
  // waits in the holding slot otherwise; the sequencer stalls while it waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= pend_valid_q || done;
      pend_valid_q <= 1'b0;
    end else if (done) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_light_q <= pend_light_q;
        out_dark_q  <= pend_dark_q;
      end else if (done) begin
        out_light_q <= light_word;
        out_dark_q  <= dark_word;
      end
    end else if (done) begin
      pend_light_q <= light_word;
      pend_dark_q  <= dark_word;
    end
  end

endmodule

// ===== rtl/plasma_word_generator_core.sv =====
// Plasma word generator: one 16-pixel word of two gray bit planes per request.
// The two-read-port table RAM serves the two table lookups of one pixel each
// cycle while the output holding slot does not stall the sequencer; a new
// request is taken in the cycle the last pixel of the previous one is read.
// Reset: asynchronous, active low; afterwards the 256-entry table is loaded
// with ready held low.
module plasma_word_generator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pwg_req_if.sink   req_i,
  pwg_rsp_if.source rsp_o
);
  import pwg_pkg::*;

  logic      hold;
  logic      tab_we;
  tab_addr_t tab_waddr;
  sine_t     tab_wdata;
  tab_addr_t raddr_a;
  tab_addr_t raddr_b;
  sine_t     rdata_a;
  sine_t     rdata_b;
  rd_tag_t   tag;

  pwg_issue u_issue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .hold_i      (hold),
    .tab_we_o    (tab_we),
    .tab_waddr_o (tab_waddr),
    .tab_wdata_o (tab_wdata),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .tag_o       (tag)
  );

  pwg_ram #(
    .WIDTH (SineW),
    .DEPTH (TableDepth)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (tab_we),
    .waddr_i   (tab_waddr),
    .wdata_i   (tab_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  pwg_shade u_shade (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .tag_i     (tag),
    .hold_o    (hold),
    .rsp_o     (rsp_o)
  );

endmodule

// ===== rtl/pwg_checker.sv =====
// Port-level checks for the plasma word generator, attached by bind.
// Depends on plasma_word_generator_core.
module pwg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] rsp_light_i,
  input logic [15:0] rsp_dark_i
);

  // A stalled response stays offered.
  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A stalled response keeps its words.
  a_rsp_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_light_i) && $stable(rsp_dark_i))
    else $error("response words changed while stalled");

  // The table is still loading right after reset, so no request is taken.
  a_load_after_reset : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !req_ready_i)
    else $error("request ready during table load");

  // No response can appear in the first cycle out of reset.
  a_no_early_rsp : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !rsp_valid_i)
    else $error("response valid right after reset");

endmodule

bind plasma_word_generator_core pwg_checker u_pwg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_light_i (rsp_o.light_word),
  .rsp_dark_i  (rsp_o.dark_word)
);
